### hdl/bff_pkg.sv
// shared types, constants and helper functions of the bitmap find-first unit
`timescale 1ns / 1ps
`default_nettype none

package bff_pkg;

  // store geometry
  localparam int MAX_BITS   = 1024;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = MAX_BITS / WORD_BITS;
  localparam int WIDX_W     = $clog2(WORD_COUNT);
  localparam int BPOS_W     = $clog2(WORD_BITS);
  localparam int IDX_W      = WIDX_W + BPOS_W;
  localparam int CNT_W      = 11;

  // operation codes
  localparam logic [1:0] OP_FILL = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;
  localparam logic [1:0] OP_FIND = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] bit_pos;
    logic             bit_value;
  } in_t;

  // result item
  typedef struct packed {
    logic [1:0]       status;
    logic             read_value;
    logic [IDX_W-1:0] found_index;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic issue;
    logic scan;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } stat_t;

  // lowest set bit of a nonzero word: pick the byte, then the bit in it
  function automatic logic [BPOS_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [7:0] byte_nz;
    logic [2:0] byte_sel;
    logic [7:0] sel_byte;
    logic [2:0] bit_sel;
    for (int i = 0; i < 8; i++) begin
      byte_nz[i] = |w[8*i +: 8];
    end
    byte_sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (byte_nz[i]) begin
        byte_sel = 3'(i);
      end
    end
    sel_byte = w[8*byte_sel +: 8];
    bit_sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (sel_byte[i]) begin
        bit_sel = 3'(i);
      end
    end
    return {byte_sel, bit_sel};
  endfunction

endpackage

`default_nettype wire

### hdl/bff_ctrl.sv
// controller state machine of the bitmap find-first unit
`timescale 1ns / 1ps
`default_nettype none

module bff_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire bff_pkg::stat_t stat,
  output bff_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_strobe
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;

  // command decode and next state
  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.issue = 1'b1;
          if (stat.need_scan) begin
            state_nxt = S_SCAN;
          end else begin
            strobe_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and strobe registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r == S_SCAN);
  assign out_strobe = strobe_r;

  // a scan that has not finished keeps the block busy
  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && !stat.scan_done) |=> busy)
    else $error("scan left before it finished");

  // every strobe comes from a finished item
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past((cmd.issue && !stat.need_scan) || (cmd.scan && stat.scan_done)))
    else $error("result strobe without a finished item");

  // issue and scan never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.issue && cmd.scan))
    else $error("issue during scan");

endmodule

`default_nettype wire

### hdl/bff_datapath.sv
// bit store, bit count register and word scanner of the bitmap find-first unit
`timescale 1ns / 1ps
`default_nettype none

module bff_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bff_pkg::cmd_t              cmd,
  input  wire bff_pkg::in_t               in_item,
  input  wire logic                       cfg_we,
  input  wire logic [bff_pkg::CNT_W-1:0]  cfg_data,
  output bff_pkg::stat_t                  stat,
  output bff_pkg::out_t                   out_item
);

  logic [bff_pkg::WORD_BITS-1:0] words_r [bff_pkg::WORD_COUNT];
  logic [bff_pkg::CNT_W-1:0]     cnt_r;
  logic [bff_pkg::WIDX_W-1:0]    ptr_r;
  logic                          val_r;
  bff_pkg::out_t                 res_r;
  bff_pkg::out_t                 res_nxt;

  logic [bff_pkg::CNT_W-1:0]     cnt_m1;
  logic [bff_pkg::WIDX_W-1:0]    last_word;
  logic                          in_range;
  logic [bff_pkg::WIDX_W-1:0]    in_word;
  logic [bff_pkg::BPOS_W-1:0]    in_bit;
  logic [bff_pkg::WORD_BITS-1:0] cur_word;
  logic [bff_pkg::WORD_BITS-1:0] tail_mask;
  logic [bff_pkg::WORD_BITS-1:0] cand;
  logic                          is_last;
  logic                          hit;

  // count decode
  assign cnt_m1    = cnt_r - bff_pkg::CNT_W'(1);
  assign last_word = cnt_m1[bff_pkg::IDX_W-1:bff_pkg::BPOS_W];
  assign in_range  = {1'b0, in_item.bit_pos} < cnt_r;
  assign in_word   = in_item.bit_pos[bff_pkg::IDX_W-1:bff_pkg::BPOS_W];
  assign in_bit    = in_item.bit_pos[bff_pkg::BPOS_W-1:0];

  // word scan: match, trim padding of the last valid word, test
  assign cur_word  = words_r[ptr_r];
  assign tail_mask = (cnt_r[bff_pkg::BPOS_W-1:0] == '0) ? '1 :
                     ~({bff_pkg::WORD_BITS{1'b1}} << cnt_r[bff_pkg::BPOS_W-1:0]);
  assign is_last   = (ptr_r == last_word);
  assign cand      = (val_r ? cur_word : ~cur_word) & (is_last ? tail_mask : '1);
  assign hit       = |cand;

  assign stat.need_scan = (in_item.operation == bff_pkg::OP_FIND) && (cnt_r != '0);
  assign stat.scan_done = hit || is_last;

  // bit count register, clamped to the store size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= bff_pkg::CNT_W'(bff_pkg::MAX_BITS);
    end else if (cfg_we) begin
      cnt_r <= (cfg_data > bff_pkg::CNT_W'(bff_pkg::MAX_BITS)) ?
               bff_pkg::CNT_W'(bff_pkg::MAX_BITS) : cfg_data;
    end
  end

  // bit store: fill and single bit write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bff_pkg::WORD_COUNT; i++) begin
        words_r[i] <= '0;
      end
    end else if (cmd.issue) begin
      if (in_item.operation == bff_pkg::OP_FILL) begin
        for (int i = 0; i < bff_pkg::WORD_COUNT; i++) begin
          words_r[i] <= {bff_pkg::WORD_BITS{in_item.bit_value}};
        end
      end else if ((in_item.operation == bff_pkg::OP_SET) && in_range) begin
        words_r[in_word][in_bit] <= in_item.bit_value;
      end
    end
  end

  // scan pointer and search value
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      ptr_r <= '0;
      val_r <= in_item.bit_value;
    end else if (cmd.scan && !stat.scan_done) begin
      ptr_r <= ptr_r + bff_pkg::WIDX_W'(1);
    end
  end

  // next result item
  always_comb begin
    res_nxt = res_r;
    if (cmd.issue && !stat.need_scan) begin
      res_nxt = '0;
      unique case (in_item.operation)
        bff_pkg::OP_GET, bff_pkg::OP_SET: begin
          if (!in_range) begin
            res_nxt.status = bff_pkg::ST_RANGE;
          end else if (in_item.operation == bff_pkg::OP_GET) begin
            res_nxt.read_value = words_r[in_word][in_bit];
          end
        end
        bff_pkg::OP_FIND: begin
          res_nxt.status = bff_pkg::ST_NONE;
        end
        bff_pkg::OP_FILL: begin
          res_nxt.status = bff_pkg::ST_OK;
        end
      endcase
    end else if (cmd.scan && stat.scan_done) begin
      res_nxt = '0;
      if (hit) begin
        res_nxt.status      = bff_pkg::ST_OK;
        res_nxt.found_index = {ptr_r, bff_pkg::lowest_set(cand)};
      end else begin
        res_nxt.status      = bff_pkg::ST_NONE;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_item = res_r;

endmodule

`default_nettype wire

### hdl/bitmap_find_first_unit.sv
// top level of the bitmap find-first unit
`timescale 1ns / 1ps
`default_nettype none

// Bit set of 1024 bits in 16 words of 64 bits, cleared at reset, with fill,
// get, set and find-first. An item is taken when start is high and busy is
// low. Fill, get and set finish when issued; find-first is issued and then
// scans words, 1 to 16 words (up to the word of the first match or the last
// word below the bit count, none when the bit count is zero), as the scanner
// reads one store word per cycle. The result shows on out_item, marked by
// out_strobe high for a single cycle, in the cycle after the item finishes;
// it must be taken then, since the receiver cannot stall the block. The bit
// count is written through cfg_valid and cfg_data while the block is idle
// (cfg_ready is low during a scan); values above 1024 act as 1024.
module bitmap_find_first_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire bff_pkg::in_t              in_item,
  output logic                           out_strobe,
  output bff_pkg::out_t                  out_item,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [bff_pkg::CNT_W-1:0] cfg_data
);

  bff_pkg::cmd_t  cmd;
  bff_pkg::stat_t stat;
  logic           start_ok;

  // new items only while idle
  assign start_ok  = start && !busy;

  // count writes only while no scan runs
  assign cfg_ready = !busy;

  // controller
  bff_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start_ok),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // datapath
  bff_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

### sim/bitmap_find_first_unit_tb.sv
// self-checking testbench of the bitmap find-first unit with an item scoreboard
`timescale 1ns / 1ps

module bitmap_find_first_unit_tb;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_GAP      = 12;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASE_ITEMS  = 62;
  localparam int NUM_PHASES   = 12;
  localparam int MAX_REPORTS  = 10;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      start     = 1'b0;
  bff_pkg::in_t              in_item   = '0;
  logic                      cfg_valid = 1'b0;
  logic [bff_pkg::CNT_W-1:0] cfg_data  = '0;
  logic                      busy;
  logic                      out_strobe;
  bff_pkg::out_t             out_item;
  logic                      cfg_ready;

  // mirror of the bit store plus the queue of predicted results
  class bitmap_scoreboard;
    logic [bff_pkg::WORD_BITS-1:0] words [bff_pkg::WORD_COUNT];
    logic [bff_pkg::CNT_W-1:0]     valid_bits;
    bff_pkg::out_t                 expected_q [$];
    int unsigned                   mismatches;
    int unsigned                   results_checked;
    int unsigned                   finds_hit;
    int unsigned                   finds_empty;
    int unsigned                   range_errs;
    int unsigned                   op_seen [4];

    function new();
      foreach (words[w]) words[w] = '0;
      valid_bits = bff_pkg::CNT_W'(bff_pkg::MAX_BITS);
      mismatches = 0;
      results_checked = 0;
      finds_hit = 0;
      finds_empty = 0;
      range_errs = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    // apply one item to the mirror and return the result it should produce
    function bff_pkg::out_t predict_result(bff_pkg::in_t item);
      bff_pkg::out_t res;
      int            limit;
      int            n;
      res = '0;
      res.status = bff_pkg::ST_OK;
      limit = (valid_bits > bff_pkg::MAX_BITS) ? bff_pkg::MAX_BITS : int'(valid_bits);
      unique case (item.operation)
        bff_pkg::OP_FILL: begin
          foreach (words[w]) words[w] = {bff_pkg::WORD_BITS{item.bit_value}};
        end
        bff_pkg::OP_GET, bff_pkg::OP_SET: begin
          if (int'(item.bit_pos) >= limit) begin
            res.status = bff_pkg::ST_RANGE;
          end else if (item.operation == bff_pkg::OP_GET) begin
            res.read_value =
              words[item.bit_pos[bff_pkg::IDX_W-1:bff_pkg::BPOS_W]]
                   [item.bit_pos[bff_pkg::BPOS_W-1:0]];
          end else begin
            words[item.bit_pos[bff_pkg::IDX_W-1:bff_pkg::BPOS_W]]
                 [item.bit_pos[bff_pkg::BPOS_W-1:0]] = item.bit_value;
          end
        end
        default: begin
          // lowest valid index holding the wanted value, padding never counts
          res.status = bff_pkg::ST_NONE;
          for (n = 0; n < limit && res.status == bff_pkg::ST_NONE; n++) begin
            if (words[n / bff_pkg::WORD_BITS][n % bff_pkg::WORD_BITS] == item.bit_value) begin
              res.status = bff_pkg::ST_OK;
              res.found_index = bff_pkg::IDX_W'(n);
            end
          end
        end
      endcase
      return res;
    endfunction

    function void note_item(bff_pkg::in_t item);
      op_seen[item.operation]++;
      expected_q.push_back(predict_result(item));
    endfunction

    function void check_result(bff_pkg::out_t got);
      bff_pkg::out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with nothing pending: status %0d read %0d found %0d",
                   $time, got.status, got.read_value, got.found_index);
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (want.status == bff_pkg::ST_RANGE) range_errs++;
      else if (want.status == bff_pkg::ST_NONE) finds_empty++;
      else if (want.found_index != '0 || want.read_value) finds_hit++;
      if (got.status !== want.status || got.read_value !== want.read_value ||
          got.found_index !== want.found_index) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] mismatch: status %0d/%0d read %0d/%0d found %0d/%0d (exp/got)",
                   $time, want.status, got.status, want.read_value, got.read_value,
                   want.found_index, got.found_index);
      end
    endfunction
  endclass

  bitmap_scoreboard sb = new();

  int unsigned idle_cycles  = 0;
  int unsigned count_writes = 0;
  logic        last_fill    = 1'b0;
  bit          burst_mode   = 1'b0;

  bitmap_find_first_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) sb.check_result(out_item);
  end

  // watchdog on cycles where no item, result or register write moves
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
        $display("bitmap_find_first_unit verification failed");
        $finish;
      end
    end
  end

  // hold off new items until every pending result has come back
  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_valid_bits(input logic [bff_pkg::CNT_W-1:0] value);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.valid_bits = value;
    count_writes++;
  endtask

  // send one item, optionally after a random gap, and wait for it to be taken
  task automatic issue(input logic [1:0] op, input int idx, input logic val);
    bff_pkg::in_t item;
    int           gap;
    item.operation = op;
    item.bit_pos   = bff_pkg::IDX_W'(idx);
    item.bit_value = val;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    sb.note_item(item);
    if (op == bff_pkg::OP_FILL) last_fill = val;
  endtask

  task automatic random_item();
    int         eff;
    int         pick;
    int         idx;
    logic [1:0] op;
    logic       val;
    eff = (sb.valid_bits > bff_pkg::MAX_BITS) ? bff_pkg::MAX_BITS : int'(sb.valid_bits);
    pick = $urandom_range(0, 99);
    if (pick < 4) op = bff_pkg::OP_FILL;
    else if (pick < 30) op = bff_pkg::OP_GET;
    else if (pick < 65) op = bff_pkg::OP_SET;
    else op = bff_pkg::OP_FIND;
    // index mostly valid, some right at the count boundary, some anywhere
    pick = $urandom_range(0, 9);
    if (eff > 0 && pick < 6) idx = $urandom_range(0, eff - 1);
    else if (eff > 0 && pick == 6) idx = eff - 1;
    else if (pick == 7 && eff < bff_pkg::MAX_BITS) idx = eff;
    else idx = $urandom_range(0, bff_pkg::MAX_BITS - 1);
    // writes and searches mostly go against the fill so matches stay sparse
    if ((op == bff_pkg::OP_SET || op == bff_pkg::OP_FIND) && $urandom_range(0, 3) != 0)
      val = ~last_fill;
    else val = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 39) == 0) wait_drain();
    issue(op, idx, val);
  endtask

  // stimulus
  initial begin
    logic [bff_pkg::CNT_W-1:0] phase_count;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: cleared store, single bits at both ends, fills, word borders
    issue(bff_pkg::OP_FIND, 0, 1'b1);
    issue(bff_pkg::OP_FIND, 0, 1'b0);
    issue(bff_pkg::OP_GET, 1023, 1'b0);
    issue(bff_pkg::OP_SET, 1023, 1'b1);
    issue(bff_pkg::OP_FIND, 0, 1'b1);
    issue(bff_pkg::OP_GET, 1023, 1'b0);
    issue(bff_pkg::OP_SET, 0, 1'b1);
    issue(bff_pkg::OP_FIND, 0, 1'b1);
    issue(bff_pkg::OP_SET, 0, 1'b0);
    issue(bff_pkg::OP_FILL, 0, 1'b1);
    issue(bff_pkg::OP_FIND, 0, 1'b0);
    issue(bff_pkg::OP_SET, 512, 1'b0);
    issue(bff_pkg::OP_FIND, 1023, 1'b0);
    issue(bff_pkg::OP_FILL, 1023, 1'b0);
    issue(bff_pkg::OP_SET, 63, 1'b1);
    issue(bff_pkg::OP_SET, 64, 1'b1);
    issue(bff_pkg::OP_FIND, 0, 1'b1);

    // single valid bit, then no valid bit, then a count above the store
    write_valid_bits(bff_pkg::CNT_W'(1));
    issue(bff_pkg::OP_GET, 1, 1'b0);
    issue(bff_pkg::OP_SET, 1, 1'b1);
    issue(bff_pkg::OP_FIND, 0, 1'b1);
    issue(bff_pkg::OP_FIND, 0, 1'b0);
    write_valid_bits(bff_pkg::CNT_W'(0));
    issue(bff_pkg::OP_GET, 0, 1'b0);
    issue(bff_pkg::OP_FIND, 0, 1'b0);
    write_valid_bits({bff_pkg::CNT_W{1'b1}});
    issue(bff_pkg::OP_GET, 1023, 1'b1);
    issue(bff_pkg::OP_FIND, 0, 1'b1);

    // random phases, each under its own bit count
    for (int p = 0; p < NUM_PHASES; p++) begin
      unique case (p)
        0:       phase_count = bff_pkg::CNT_W'(1024);
        1:       phase_count = bff_pkg::CNT_W'(1);
        2:       phase_count = bff_pkg::CNT_W'(63);
        3:       phase_count = bff_pkg::CNT_W'(64);
        4:       phase_count = bff_pkg::CNT_W'(65);
        5:       phase_count = {bff_pkg::CNT_W{1'b1}};
        6:       phase_count = bff_pkg::CNT_W'(0);
        7:       phase_count = bff_pkg::CNT_W'(700);
        8:       phase_count = bff_pkg::CNT_W'(1023);
        9:       phase_count = bff_pkg::CNT_W'($urandom_range(0, 2047));
        10:      phase_count = bff_pkg::CNT_W'($urandom_range(1, 1024));
        default: phase_count = bff_pkg::CNT_W'(1024);
      endcase
      write_valid_bits(phase_count);
      burst_mode = (p % 3 == 1);
      repeat (PHASE_ITEMS) random_item();
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d fill, %0d get, %0d set, %0d find items over %0d bit count writes",
             sb.op_seen[bff_pkg::OP_FILL], sb.op_seen[bff_pkg::OP_GET],
             sb.op_seen[bff_pkg::OP_SET], sb.op_seen[bff_pkg::OP_FIND], count_writes);
    $display("checked %0d results: %0d nonzero hits or reads, %0d empty finds, %0d %s",
             sb.results_checked, sb.finds_hit, sb.finds_empty, sb.range_errs,
             "out of range");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("bitmap_find_first_unit verification clean");
    end else begin
      $display("%0d bad results, %0d results never arrived",
               sb.mismatches, sb.expected_q.size());
      $display("bitmap_find_first_unit verification failed");
    end
    $finish;
  end

endmodule
